@@ rtl/svalloc_pkg.sv @@
package svalloc_pkg;

    // Sizing of the channel bank and the effect table.
    localparam int CHANNELS    = 4;
    localparam int NUM_SOUNDS  = 128;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SND_W       = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QD_W        = $clog2(QUEUE_DEPTH);

    // Fixed arithmetic constants.
    localparam logic [6:0]  FULL_VOL      = 7'd127;
    localparam logic [31:0] THROTTLE_TICS = 32'd2;
    localparam int          DIST_SHIFT    = 20;
    localparam int          QUAD_SHIFT    = 3;
    localparam int          LEN_SHIFT     = 2;

    // Result status codes.
    localparam logic [3:0] ST_STARTED   = 4'd0;
    localparam logic [3:0] ST_MUTED     = 4'd1;
    localparam logic [3:0] ST_BAD_ID    = 4'd2;
    localparam logic [3:0] ST_FAR       = 4'd3;
    localparam logic [3:0] ST_NO_DATA   = 4'd4;
    localparam logic [3:0] ST_AMBIENT   = 4'd5;
    localparam logic [3:0] ST_THROTTLED = 4'd6;
    localparam logic [3:0] ST_DUPLICATE = 4'd7;
    localparam logic [3:0] ST_NO_CHAN   = 4'd8;

    // Sound classes.
    localparam logic [1:0] CLS_AMBIENT = 2'd1;
    localparam logic [1:0] CLS_COMBAT  = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_W        = 2;
    localparam logic [1:0] REG_SFX_VOLUME   = 2'd0;
    localparam logic [1:0] REG_MUSIC_VOLUME = 2'd1;
    localparam logic [1:0] REG_MUSIC_LOADED = 2'd2;

    typedef struct packed {
        logic [6:0]         effect_id;
        logic [15:0]        origin_id;
        logic               is_listener;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic               has_data;
        logic [7:0]         priority_req;
        logic               singular;
        logic [23:0]        length_samples;
        logic [1:0]         sound_class;
        logic [31:0]        sample_count;
        logic [31:0]        game_tic;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  channel;
        logic [14:0] volume;
        logic [31:0] start_quad;
        logic [31:0] stop_quad;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] addr;
        logic [7:0]           wdata;
    } t_cfg;

    typedef struct packed {
        logic [7:0] sfx_volume;
        logic [7:0] music_volume;
        logic       music_loaded;
    } t_cfg_regs;

    // A classified request on its way from the front to the back.
    typedef struct packed {
        logic [3:0]  status;
        logic [6:0]  effect_id;
        logic [15:0] origin_id;
        logic [7:0]  priority_req;
        logic        singular;
        logic [23:0] length_samples;
        logic        throttle;
        logic [31:0] sample_count;
        logic [31:0] game_tic;
        logic [6:0]  dist_vol;
    } t_job;

    // True when the wrapped difference a - b is negative.
    function automatic logic wrap_neg(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

endpackage

@@ rtl/svalloc_if.sv @@
interface svalloc_req_if;
    logic               valid;
    logic               ready;
    svalloc_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface svalloc_res_if;
    logic               valid;
    logic               ready;
    svalloc_pkg::t_res  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface svalloc_cfg_if;
    logic               valid;
    logic               ready;
    svalloc_pkg::t_cfg  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/svalloc_front.sv @@
module svalloc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    svalloc_req_if.sink            i_req,
    input  svalloc_pkg::t_cfg_regs i_cfg_regs,
    output logic                   o_job_valid,
    output svalloc_pkg::t_job      o_job,
    input  logic                   i_job_ready
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MAG  = 2'd1;
    localparam logic [1:0] F_DIST = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    svalloc_pkg::t_req r_req;
    logic [31:0]       r_dx;
    logic [31:0]       r_dy;
    logic [31:0]       r_mn;

    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [32:0] dist_sum;
    logic [12:0] dist_d;
    logic        music_on;
    logic        full_vol;

    assign i_req.ready = (r_state == F_IDLE);

    // Magnitudes of the deltas; the most negative value maps to 2^31.
    assign mag_x = r_req.delta_x[31] ? (~r_req.delta_x + 32'd1) : r_req.delta_x;
    assign mag_y = r_req.delta_y[31] ? (~r_req.delta_y + 32'd1) : r_req.delta_y;

    // Octagonal distance estimate in map units.
    assign dist_sum = {1'b0, r_dx} + {1'b0, r_dy} - {2'b00, r_mn[31:1]};
    assign dist_d   = dist_sum[32:svalloc_pkg::DIST_SHIFT];

    assign music_on = i_cfg_regs.music_loaded && (i_cfg_regs.music_volume != 8'd0);
    assign full_vol = r_req.is_listener || (r_req.origin_id == 16'd0);

    // Classification of the request, in order of precedence.
    always_comb begin
        o_job                = '0;
        o_job.effect_id      = r_req.effect_id;
        o_job.origin_id      = r_req.origin_id;
        o_job.priority_req   = r_req.priority_req;
        o_job.singular       = r_req.singular;
        o_job.length_samples = r_req.length_samples;
        o_job.sample_count   = r_req.sample_count;
        o_job.game_tic       = r_req.game_tic;
        o_job.throttle       = music_on && (r_req.sound_class == svalloc_pkg::CLS_COMBAT);
        o_job.dist_vol       = full_vol ? svalloc_pkg::FULL_VOL
                                        : (svalloc_pkg::FULL_VOL - dist_d[6:0]);
        if (i_cfg_regs.sfx_volume == 8'd0) begin
            o_job.status = svalloc_pkg::ST_MUTED;
        end else if ((r_req.effect_id == 7'd0)
                     || (32'(r_req.effect_id) >= 32'(svalloc_pkg::NUM_SOUNDS))) begin
            o_job.status = svalloc_pkg::ST_BAD_ID;
        end else if (!full_vol && (dist_d > 13'(svalloc_pkg::FULL_VOL))) begin
            o_job.status = svalloc_pkg::ST_FAR;
        end else if (!r_req.has_data) begin
            o_job.status = svalloc_pkg::ST_NO_DATA;
        end else if (music_on && (r_req.sound_class == svalloc_pkg::CLS_AMBIENT)) begin
            o_job.status = svalloc_pkg::ST_AMBIENT;
        end else begin
            o_job.status = svalloc_pkg::ST_STARTED;
        end
    end

    assign o_job_valid = (r_state == F_DIST);

    // Sequencer: capture, magnitudes, then hand over to the queue.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_req.valid) n_state = F_MAG;
            F_MAG:   n_state = F_DIST;
            F_DIST:  if (i_job_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == F_IDLE) && i_req.valid) begin
            r_req <= i_req.data;
        end
        if (r_state == F_MAG) begin
            r_dx <= mag_x;
            r_dy <= mag_y;
            r_mn <= (mag_x < mag_y) ? mag_x : mag_y;
        end
    end

endmodule

@@ rtl/svalloc_queue.sv @@
module svalloc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  svalloc_pkg::t_job i_push_data,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output svalloc_pkg::t_job o_pop_data,
    input  logic              i_pop
);

    svalloc_pkg::t_job       r_mem [svalloc_pkg::QUEUE_DEPTH];
    logic [svalloc_pkg::QD_W-1:0] r_wr_ptr;
    logic [svalloc_pkg::QD_W-1:0] r_rd_ptr;
    logic [svalloc_pkg::QD_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != (svalloc_pkg::QD_W+1)'(svalloc_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == svalloc_pkg::QD_W'(svalloc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == svalloc_pkg::QD_W'(svalloc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/svalloc_back.sv @@
module svalloc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  svalloc_pkg::t_cfg_regs i_cfg_regs,
    input  logic                   i_job_valid,
    input  svalloc_pkg::t_job      i_job,
    output logic                   o_job_pop,
    svalloc_res_if.source          o_res
);

    localparam int CH_W  = svalloc_pkg::CH_W;
    localparam int SND_W = svalloc_pkg::SND_W;
    localparam int NCH   = svalloc_pkg::CHANNELS;
    localparam int NSND  = svalloc_pkg::NUM_SOUNDS;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_THR  = 3'd1;
    localparam logic [2:0] B_QUAD = 3'd2;
    localparam logic [2:0] B_SCAN = 3'd3;
    localparam logic [2:0] B_PRIO = 3'd4;
    localparam logic [2:0] B_WR   = 3'd5;
    localparam logic [2:0] B_EMIT = 3'd6;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NCH - 1);

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    svalloc_pkg::t_job r_job;
    logic [31:0]       r_final;
    logic [CH_W-1:0]   r_idx;
    logic [CH_W-1:0]   r_found;
    logic              r_has_dead;
    svalloc_pkg::t_res r_pend;
    svalloc_pkg::t_res r_out;
    logic              r_out_valid;

    // Channel bank.
    logic [6:0]  r_ch_sound  [NCH];
    logic [15:0] r_ch_origin [NCH];
    logic [31:0] r_ch_start  [NCH];
    logic [31:0] r_ch_stop   [NCH];
    logic [7:0]  r_ch_prio   [NCH];
    logic [14:0] r_ch_volume [NCH];

    // Throttle table: memory plus a valid bit per effect cleared at reset.
    logic [31:0]     r_tic_mem [NSND];
    logic [NSND-1:0] r_tic_valid;
    logic [31:0]     r_tic_rd;
    logic            r_tic_hit;

    logic [SND_W-1:0] head_idx;
    logic [SND_W-1:0] job_idx;
    logic [31:0]      last_tic;
    logic [31:0]      elapsed;
    logic             throttled;
    logic [31:0]      cur_quad;
    logic             sound_eq;
    logic             dup_hit;
    logic             take_hit;
    logic             dead_hit;
    logic             prio_hit;
    logic             out_free;
    logic             tic_write;
    logic [14:0]      vol_out;
    logic [31:0]      stop_new;

    assign head_idx  = SND_W'(i_job.effect_id);
    assign job_idx   = SND_W'(r_job.effect_id);
    assign o_job_pop = (r_state == B_IDLE) && i_job_valid;

    // Repeat throttling on the recorded start tic.
    assign last_tic  = r_tic_hit ? r_tic_rd : 32'd0;
    assign elapsed   = r_job.game_tic - last_tic;
    assign throttled = (last_tic != 32'd0)
                       && (elapsed[31] || (elapsed < svalloc_pkg::THROTTLE_TICS));
    assign tic_write = (r_state == B_THR) && !throttled;

    assign cur_quad = r_job.sample_count >> svalloc_pkg::QUAD_SHIFT;

    // Tests on the channel under the scan pointer.
    assign sound_eq = (r_ch_sound[r_idx] == r_job.effect_id);
    assign dup_hit  = sound_eq && (r_ch_start[r_idx] == r_final);
    assign take_hit = (sound_eq && r_job.singular) || (r_ch_origin[r_idx] == r_job.origin_id);
    assign dead_hit = (r_ch_stop[r_idx] == r_final)
                      || svalloc_pkg::wrap_neg(r_ch_stop[r_idx], r_final);
    assign prio_hit = (r_ch_prio[r_idx] >= r_job.priority_req);

    assign vol_out  = 15'(r_job.dist_vol) * 15'(i_cfg_regs.sfx_volume);
    assign stop_new = r_final + 32'(r_job.length_samples >> svalloc_pkg::LEN_SHIFT);

    assign out_free = !r_out_valid || o_res.ready;

    // Sequencer of the back end.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.status != svalloc_pkg::ST_STARTED) n_state = B_EMIT;
                    else if (i_job.throttle)                      n_state = B_THR;
                    else                                          n_state = B_QUAD;
                end
            end
            B_THR:   n_state = throttled ? B_EMIT : B_QUAD;
            B_QUAD:  n_state = B_SCAN;
            B_SCAN: begin
                if (dup_hit)                                 n_state = B_EMIT;
                else if (take_hit)                           n_state = B_WR;
                else if (r_idx == LAST_CH)                   n_state = (dead_hit || r_has_dead)
                                                                       ? B_WR : B_PRIO;
            end
            B_PRIO: begin
                if (prio_hit)              n_state = B_WR;
                else if (r_idx == LAST_CH) n_state = B_EMIT;
            end
            B_WR:    n_state = B_EMIT;
            B_EMIT:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Control registers and channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_final     <= '0;
            r_out_valid <= 1'b0;
            r_tic_valid <= '0;
            r_idx       <= '0;
            r_found     <= '0;
            r_has_dead  <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                r_ch_sound[i]  <= '0;
                r_ch_origin[i] <= '0;
                r_ch_start[i]  <= '0;
                r_ch_stop[i]   <= '0;
                r_ch_prio[i]   <= '0;
                r_ch_volume[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (tic_write) begin
                r_tic_valid[job_idx] <= 1'b1;
            end
            unique case (r_state)
                B_QUAD: begin
                    if (svalloc_pkg::wrap_neg(r_final, cur_quad)) begin
                        r_final <= cur_quad;
                    end
                    r_idx      <= '0;
                    r_has_dead <= 1'b0;
                end
                B_SCAN: begin
                    if (!dup_hit) begin
                        if (take_hit || dead_hit) begin
                            r_found <= r_idx;
                        end
                        if (dead_hit) begin
                            r_has_dead <= 1'b1;
                        end
                        r_idx <= (r_idx == LAST_CH) ? '0 : r_idx + 1'b1;
                    end
                end
                B_PRIO: begin
                    if (prio_hit) begin
                        r_found <= r_idx;
                    end else if (r_idx != LAST_CH) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                B_WR: begin
                    r_ch_sound[r_found]  <= r_job.effect_id;
                    r_ch_origin[r_found] <= r_job.origin_id;
                    r_ch_start[r_found]  <= r_final;
                    r_ch_stop[r_found]   <= stop_new;
                    r_ch_prio[r_found]   <= r_job.priority_req;
                    r_ch_volume[r_found] <= vol_out;
                end
                default: begin
                end
            endcase
            // Output register: loaded from the pending result, cleared on transfer.
            if ((r_state == B_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job             <= i_job;
            r_tic_rd          <= r_tic_mem[head_idx];
            r_tic_hit         <= r_tic_valid[head_idx];
            r_pend.status     <= i_job.status;
            r_pend.channel    <= '0;
            r_pend.volume     <= '0;
            r_pend.start_quad <= '0;
            r_pend.stop_quad  <= '0;
        end
        if ((r_state == B_THR) && throttled) begin
            r_pend.status <= svalloc_pkg::ST_THROTTLED;
        end
        if ((r_state == B_SCAN) && dup_hit) begin
            r_pend.status <= svalloc_pkg::ST_DUPLICATE;
        end
        if ((r_state == B_PRIO) && !prio_hit && (r_idx == LAST_CH)) begin
            r_pend.status <= svalloc_pkg::ST_NO_CHAN;
        end
        if (r_state == B_WR) begin
            r_pend.status     <= svalloc_pkg::ST_STARTED;
            r_pend.channel    <= 2'(r_found);
            r_pend.volume     <= vol_out;
            r_pend.start_quad <= r_final;
            r_pend.stop_quad  <= stop_new;
        end
        if ((r_state == B_EMIT) && out_free) begin
            r_out <= r_pend;
        end
        if (tic_write) begin
            r_tic_mem[job_idx] <= r_job.game_tic;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

@@ rtl/sound_voice_allocator_unit.sv @@
// The front captures a request, takes the magnitudes of the deltas, then estimates
// the distance and classifies it; the back checks the throttle when it is flagged,
// then walks the channels one per cycle in a match scan and, if no match or dead
// channel turns up, in a priority scan, before it writes the channel and emits.
// The front takes a new request only once its job is in the queue; the back pops
// a new job only after its last result has entered the output register.
// Reset (synchronous, active low) clears channels, final quad, throttle valid bits,
// the queue and the output register at once, and loads the register defaults.
module sound_voice_allocator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    svalloc_req_if.sink   i_req,
    svalloc_cfg_if.sink   i_cfg,
    svalloc_res_if.source o_res
);

    svalloc_pkg::t_cfg_regs r_cfg;
    svalloc_pkg::t_job      front_job;
    svalloc_pkg::t_job      queue_job;
    logic                   front_valid;
    logic                   queue_ready;
    logic                   queue_valid;
    logic                   back_pop;

    assign i_cfg.ready = 1'b1;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sfx_volume   <= 8'd132;
            r_cfg.music_volume <= 8'd100;
            r_cfg.music_loaded <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.addr)
                svalloc_pkg::REG_SFX_VOLUME:   r_cfg.sfx_volume   <= i_cfg.data.wdata;
                svalloc_pkg::REG_MUSIC_VOLUME: r_cfg.music_volume <= i_cfg.data.wdata;
                svalloc_pkg::REG_MUSIC_LOADED: r_cfg.music_loaded <= i_cfg.data.wdata[0];
                default: begin
                end
            endcase
        end
    end

    svalloc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_regs  (r_cfg),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (queue_ready)
    );

    svalloc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_job),
        .o_push_ready (queue_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_data   (queue_job),
        .i_pop        (back_pop)
    );

    svalloc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_regs  (r_cfg),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (back_pop),
        .o_res       (o_res)
    );

endmodule

@@ rtl/svalloc_chk.sv @@
module svalloc_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input svalloc_pkg::t_res i_res_data
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_data))
        else $error("result payload changed while stalled");

    // A rejected request carries no channel, volume or quads.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_data.status != svalloc_pkg::ST_STARTED) |->
        (i_res_data.channel == 2'd0) && (i_res_data.volume == 15'd0)
        && (i_res_data.start_quad == 32'd0) && (i_res_data.stop_quad == 32'd0))
        else $error("rejected result with nonzero fields");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_data.status <= svalloc_pkg::ST_NO_CHAN))
        else $error("undefined status code");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind sound_voice_allocator_unit svalloc_chk u_svalloc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
